// File: rtl/core/sensor_frame_checksum_parser_core_assert.svh
// Assertion macros used by the parser controller.
// Each macro expects signals named clk and rst_n in the scope of use.
`ifndef SENSOR_FRAME_CHECKSUM_PARSER_CORE_ASSERT_SVH
`define SENSOR_FRAME_CHECKSUM_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFCP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SFCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/sfcp_pkg.sv
package sfcp_pkg;

  localparam logic [7:0] START_BYTE = 8'hAA;
  localparam logic [7:0] END_BYTE   = 8'hFF;
  localparam int unsigned FRAME_LEN = 7;
  localparam logic [2:0] LAST_SLOT  = 3'd6;
  localparam logic [2:0] CSUM_SLOT  = 3'd5;

  // 1000 * 0.3 * 5 / 1024 scaling folded into raw * 375 / 256.
  localparam logic [8:0]  CONC_MUL    = 9'd375;
  // floor(2^19 / 100): gives a quotient estimate at most one too small.
  localparam logic [12:0] RECIP_100   = 13'd5242;
  // 205 / 2048 is exact for dividing values below 100 by ten.
  localparam logic [7:0]  RECIP_10    = 8'd205;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SAT,
    S_DIV,
    S_FIX,
    S_DIG,
    S_EMIT
  } sfcp_state_t;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic       sat_en;
    logic       div_en;
    logic       fix_en;
    logic       dig_en;
    logic [2:0] emit_idx;
  } sfcp_cmd_t;

  typedef struct packed {
    logic fire;
  } sfcp_status_t;

endpackage

// File: rtl/core/sfcp_dpath.sv
module sfcp_dpath
  import sfcp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic [7:0]   in_rx_byte,
  input  sfcp_cmd_t    cmd,
  output sfcp_status_t status,
  output logic [7:0]   echo_byte,
  output logic [15:0]  concentration,
  output logic [9:0]   digit_hundreds,
  output logic [3:0]   digit_tens,
  output logic [3:0]   digit_ones
);

  logic [7:0]  store_r [FRAME_LEN];
  logic [2:0]  slot_r;
  logic [24:0] prod_r;
  logic [15:0] conc_r;
  logic [28:0] qprod_r;
  logic [9:0]  hund_r;
  logic [6:0]  rem_r;
  logic [3:0]  tens_r;
  logic [3:0]  ones_r;

  logic [7:0]  sum_w;
  logic [2:0]  slot_inc;
  logic [9:0]  q_est;
  logic [16:0] rem_full;
  logic [14:0] tprod;
  logic [3:0]  tens_w;

  assign sum_w    = store_r[1] + store_r[2] + store_r[3] + store_r[4];
  assign slot_inc = slot_r + 3'd1;

  // The byte being taken completes a good frame.
  assign status.fire = (in_rx_byte != START_BYTE) && (slot_r == CSUM_SLOT) &&
                       (in_rx_byte == END_BYTE) && (sum_w == store_r[CSUM_SLOT]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      for (int k = 0; k < FRAME_LEN; k++) begin
        store_r[k] <= '0;
      end
    end else if (cmd.load) begin
      if (in_rx_byte == START_BYTE) begin
        slot_r     <= '0;
        store_r[0] <= in_rx_byte;
      end else if (slot_r < LAST_SLOT) begin
        slot_r            <= slot_inc;
        store_r[slot_inc] <= in_rx_byte;
      end
    end
  end

  assign q_est    = qprod_r[28:19];
  assign rem_full = {1'b0, conc_r} - 17'(q_est) * 17'd100;
  assign tprod    = 15'(rem_r) * 15'(RECIP_10);
  assign tens_w   = tprod[14:11];

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= 25'({store_r[1], store_r[2]}) * 25'(CONC_MUL);
    end
    if (cmd.sat_en) begin
      conc_r <= prod_r[24] ? 16'hFFFF : prod_r[23:8];
    end
    if (cmd.div_en) begin
      qprod_r <= 29'(conc_r) * 29'(RECIP_100);
    end
    if (cmd.fix_en) begin
      if (rem_full >= 17'd100) begin
        hund_r <= q_est + 10'd1;
        rem_r  <= 7'(rem_full - 17'd100);
      end else begin
        hund_r <= q_est;
        rem_r  <= rem_full[6:0];
      end
    end
    if (cmd.dig_en) begin
      tens_r <= tens_w;
      ones_r <= 4'(rem_r - 7'(tens_w) * 7'd10);
    end
  end

  assign echo_byte      = store_r[cmd.emit_idx];
  assign concentration  = conc_r;
  assign digit_hundreds = hund_r;
  assign digit_tens     = tens_r;
  assign digit_ones     = ones_r;

endmodule

// File: rtl/core/sfcp_ctrl.sv
`include "sensor_frame_checksum_parser_core_assert.svh"

module sfcp_ctrl
  import sfcp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  output logic         last_of_run,
  input  sfcp_status_t status,
  output sfcp_cmd_t    cmd
);

  sfcp_state_t state_r, state_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        in_acc;
  logic        out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc && status.fire) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_SAT;
      S_SAT:  state_nxt = S_DIV;
      S_DIV:  state_nxt = S_FIX;
      S_FIX:  state_nxt = S_DIG;
      S_DIG:  state_nxt = S_EMIT;
      S_EMIT: if (out_acc && cnt_r == LAST_SLOT) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // The echo counter returns to zero together with the leave from the run.
  always_comb begin
    cnt_nxt = cnt_r;
    if (state_r != S_EMIT) begin
      cnt_nxt = '0;
    end else if (out_acc) begin
      cnt_nxt = (cnt_r == LAST_SLOT) ? 3'd0 : cnt_r + 3'd1;
    end
  end

  always_comb begin
    in_stall     = (state_r != S_IDLE);
    out_valid    = (state_r == S_EMIT);
    last_of_run  = (state_r == S_EMIT) && (cnt_r == LAST_SLOT);
    cmd.load     = (state_r == S_IDLE) && in_valid;
    cmd.mul_en   = (state_r == S_MUL);
    cmd.sat_en   = (state_r == S_SAT);
    cmd.div_en   = (state_r == S_DIV);
    cmd.fix_en   = (state_r == S_FIX);
    cmd.dig_en   = (state_r == S_DIG);
    cmd.emit_idx = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `SFCP_ASSERT_NEXT(a_fire_starts_calc, in_acc && status.fire, state_r == S_MUL, "no calc")
  `SFCP_ASSERT_NEXT(a_last_ends_run, out_acc && last_of_run, !out_valid, "run not ended")
  `SFCP_ASSERT_NOW(a_cnt_idle_zero, state_r != S_EMIT, cnt_r == 3'd0, "echo count not clear")
  `SFCP_ASSERT_NEXT(a_stall_holds_idx, out_valid && out_stall, $stable(cnt_r), "index moved")

endmodule

// File: rtl/core/sensor_frame_checksum_parser_core.sv
// A byte that completes a good frame raises out_valid for its first echo item
// once the controller has stepped through the multiply, saturate, divide, fix
// and digit states; then one item per cycle for seven items unless stalled.
// Bytes that emit nothing are taken back to back while idle; a completing byte
// stalls input for the five-step concentration and digit sequence and seven echoes.
// Reset (rst_n low, synchronous): frame store and slot index cleared to zero,
// controller returns to idle, no result pending.
module sensor_frame_checksum_parser_core
  import sfcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_echo_byte,
  output logic        out_last_of_run,
  output logic [15:0] out_concentration,
  output logic [9:0]  out_digit_hundreds,
  output logic [3:0]  out_digit_tens,
  output logic [3:0]  out_digit_ones
);

  // The controller sequences the work: it takes one byte at a time while idle,
  // and when the datapath reports that the byte completes a frame with a good
  // end byte and checksum, it walks the datapath through multiply, saturate,
  // reciprocal divide, quotient correction and digit split, one step a cycle.
  sfcp_cmd_t    cmd;
  sfcp_status_t status;

  sfcp_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .last_of_run (out_last_of_run),
    .status      (status),
    .cmd         (cmd)
  );

  // The datapath holds the seven-byte frame store and the slot index. Bytes
  // after the end slot are ignored until the next start byte. The result
  // registers stay fixed during the echo run, so each item's payload is
  // stable while the receiver stalls.
  sfcp_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_rx_byte     (in_rx_byte),
    .cmd            (cmd),
    .status         (status),
    .echo_byte      (out_echo_byte),
    .concentration  (out_concentration),
    .digit_hundreds (out_digit_hundreds),
    .digit_tens     (out_digit_tens),
    .digit_ones     (out_digit_ones)
  );

endmodule
